// File: rtl/tcgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcgs_pkg;

  localparam int GEAR_SLOTS_DEF = 7;
  localparam int GEAR_W         = 4;
  localparam int Q16_W          = 16;
  localparam int TIME_W         = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int TOP_W          = 3;
  localparam int DIV_STEPS      = Q16_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [Q16_W-1:0] DEPRESS_RST = 16'd100;
  localparam logic [Q16_W-1:0] APPLY_RST   = 16'd300;
  localparam logic [TOP_W-1:0] TOP_RST     = 3'd6;
  localparam logic             BLIP_RST    = 1'b0;
  localparam logic             AUTO_RST    = 1'b1;

  // 0.7 in q0.16, rounded to nearest
  localparam logic [Q16_W-1:0] BLIP_Q16 = 16'd45875;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPRESS = 3'd0,
    REG_APPLY   = 3'd1,
    REG_TOP     = 3'd2,
    REG_BLIP    = 3'd3,
    REG_AUTO    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_step;
    logic store;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic need_ramp;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/tcgs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcgs_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] throttle_in;
  logic [15:0] clutch_in;
  logic        shift_up_btn;
  logic        shift_down_btn;
  logic [31:0] now_ms;

  modport source (output valid, throttle_in, clutch_in, shift_up_btn, shift_down_btn, now_ms,
                  input ready);
  modport sink (input valid, throttle_in, clutch_in, shift_up_btn, shift_down_btn, now_ms,
                output ready);
endinterface

interface tcgs_res_if;
  logic              valid;
  logic              ready;
  logic signed [3:0] gear;
  logic [15:0]       clutch_out;
  logic [15:0]       throttle_out;
  logic              busy_res;

  modport source (output valid, gear, clutch_out, throttle_out, busy_res, input ready);
  modport sink (input valid, gear, clutch_out, throttle_out, busy_res, output ready);
endinterface

interface tcgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/tcgs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcgs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  input  tcgs_pkg::sts_t sts,
  output tcgs_pkg::cmd_t cmd
);
  import tcgs_pkg::*;

  state_t               state;
  state_t               state_next;
  logic                 sel;
  logic [DIV_CNT_W-1:0] cnt;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EVAL) begin
        sel <= 1'b0;
      end else if (state == ST_STORE) begin
        sel <= 1'b1;
      end
      if (state == ST_MUL) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.need_ramp ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_LAST) state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = sel ? ST_OUT : ST_MUL;
      end
      ST_OUT: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = sel;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = !rst;
        cmd.load  = req_valid && !rst;
      end
      ST_EVAL:  cmd.eval = 1'b1;
      ST_MUL:   cmd.mul = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_STORE: cmd.store = 1'b1;
      ST_OUT:   res_valid = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tcgs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcgs_dp #(
  parameter int GEAR_SLOTS = tcgs_pkg::GEAR_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tcgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcgs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tcgs_pkg::Q16_W-1:0]         throttle_in,
  input  logic [tcgs_pkg::Q16_W-1:0]         clutch_in,
  input  logic                               shift_up_btn,
  input  logic                               shift_down_btn,
  input  logic [tcgs_pkg::TIME_W-1:0]        now_ms,
  input  tcgs_pkg::cmd_t                     cmd,
  output tcgs_pkg::sts_t                     sts,
  output logic signed [tcgs_pkg::GEAR_W-1:0] gear,
  output logic [tcgs_pkg::Q16_W-1:0]         clutch_out,
  output logic [tcgs_pkg::Q16_W-1:0]         throttle_out,
  output logic                               busy_res
);
  import tcgs_pkg::*;

  localparam int GW = $clog2(GEAR_SLOTS + 2) + 2;
  localparam logic signed [GW-1:0] G_SLOTS = GW'(GEAR_SLOTS);
  localparam logic signed [GW-1:0] G_REV   = '1;
  localparam logic signed [GW-1:0] G_ZERO  = '0;
  localparam logic signed [GW-1:0] G_ONE   = GW'(1);

  // configuration
  logic [Q16_W-1:0] depress;
  logic [Q16_W-1:0] apply;
  logic [TOP_W-1:0] top_gear;
  logic             blip_en;
  logic             auto_mode;

  // shift state
  logic signed [GW-1:0] gear_now;
  logic                 up_active;
  logic                 down_active;
  logic                 stepped;
  logic [TIME_W-1:0]    shift_start;
  logic                 prev_up;
  logic                 prev_dn;

  // latched request
  logic [Q16_W-1:0]  thr_r;
  logic [Q16_W-1:0]  clu_r;
  logic              up_r;
  logic              dn_r;
  logic [TIME_W-1:0] now_r;

  // ramp unit
  logic [Q16_W-1:0]       el_lo;
  logic [Q16_W-1:0]       rem;
  logic [Q16_W-1:0]       quo;
  logic [2*Q16_W-1:0]     prod;
  logic [Q16_W:0]         trial;
  logic                   fits;

  // result
  logic signed [GW-1:0] gear_res;
  logic [Q16_W-1:0]     thr_res;
  logic [Q16_W-1:0]     clu_res;
  logic                 busy_q;

  // step logic
  logic signed [GW-1:0] top_s;
  logic signed [GW-1:0] gsum;
  logic signed [GW-1:0] gear_n;
  logic [TIME_W-1:0]    el_cur;
  logic [TIME_W-1:0]    el_new;
  logic [TIME_W-1:0]    dep32;
  logic [TIME_W-1:0]    app32;
  logic [TIME_W-1:0]    start_n;
  logic                 up_n;
  logic                 dn_n;
  logic                 st_n;
  logic                 run;
  logic                 dir_up;
  logic                 ramp;
  logic                 clr_prev;
  logic [Q16_W-1:0]     thr_o;
  logic [Q16_W-1:0]     clu_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      depress   <= DEPRESS_RST;
      apply     <= APPLY_RST;
      top_gear  <= TOP_RST;
      blip_en   <= BLIP_RST;
      auto_mode <= AUTO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPRESS: depress   <= cfg_data;
        REG_APPLY:   apply     <= cfg_data;
        REG_TOP:     top_gear  <= cfg_data[TOP_W-1:0];
        REG_BLIP:    blip_en   <= cfg_data[0];
        REG_AUTO:    auto_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      thr_r <= throttle_in;
      clu_r <= clutch_in;
      up_r  <= shift_up_btn;
      dn_r  <= shift_down_btn;
      now_r <= now_ms;
    end
  end

  always_comb begin
    dep32  = TIME_W'(depress);
    app32  = TIME_W'(apply);
    el_cur = now_r - shift_start;
    top_s  = (GW'(top_gear) > G_SLOTS) ? G_SLOTS : GW'(top_gear);
    gsum   = dir_up ? gear_now + G_ONE : gear_now + G_REV;
  end

  always_comb begin
    up_n    = up_active;
    dn_n    = down_active;
    st_n    = stepped;
    start_n = shift_start;
    gear_n  = gear_now;
    thr_o   = thr_r;
    clu_o   = clu_r;
    run     = 1'b0;
    dir_up  = 1'b0;
    ramp    = 1'b0;
    if ((up_r && gear_now < top_s) || up_active) begin
      dir_up = 1'b1;
      if (!prev_up && !up_active) begin
        start_n = now_r;
        up_n    = 1'b1;
        st_n    = 1'b0;
      end else if (up_active) begin
        run = 1'b1;
      end
    end else if ((dn_r && gear_now >= G_ZERO) || down_active) begin
      if (!prev_dn && !down_active) begin
        start_n = now_r;
        dn_n    = 1'b1;
        st_n    = 1'b0;
      end else if (down_active) begin
        run = 1'b1;
      end
    end
    if (run) begin
      thr_o = '0;
      if (el_cur < dep32) begin
        clu_o = '0;
        if (!dir_up && blip_en && auto_mode && gear_now > G_ONE) thr_o = BLIP_Q16;
      end else if (el_cur > dep32 && el_cur < app32) begin
        ramp = 1'b1;
      end
      if (el_cur > app32) begin
        thr_o = thr_r;
        clu_o = clu_r;
        if (dir_up) up_n = 1'b0;
        else dn_n = 1'b0;
      end
      if (!stepped && el_cur > dep32) begin
        if (gsum > G_SLOTS) gear_n = G_SLOTS;
        else if (gsum < G_REV) gear_n = G_REV;
        else gear_n = gsum;
        st_n = 1'b1;
      end
    end
    el_new   = now_r - start_n;
    clr_prev = (el_new > dep32) && !auto_mode;
  end

  assign sts.need_ramp = ramp;

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_now    <= G_ZERO;
      up_active   <= 1'b0;
      down_active <= 1'b0;
      stepped     <= 1'b0;
      shift_start <= '0;
      prev_up     <= 1'b0;
      prev_dn     <= 1'b0;
    end else if (cmd.eval) begin
      gear_now    <= gear_n;
      up_active   <= up_n;
      down_active <= dn_n;
      stepped     <= st_n;
      shift_start <= start_n;
      prev_up     <= up_r && !clr_prev;
      prev_dn     <= dn_r && !clr_prev;
    end
  end

  // restoring divide of el * demand by apply, one quotient bit a cycle
  assign prod  = el_lo * (cmd.sel ? clu_r : thr_r);
  assign trial = {rem, quo[Q16_W-1]};
  assign fits  = trial >= {1'b0, apply};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      el_lo    <= el_cur[Q16_W-1:0];
      gear_res <= gear_n;
      thr_res  <= thr_o;
      clu_res  <= clu_o;
      busy_q   <= up_n || dn_n;
    end
    if (cmd.mul) begin
      rem <= prod[2*Q16_W-1:Q16_W];
      quo <= prod[Q16_W-1:0];
    end else if (cmd.div_step) begin
      rem <= fits ? Q16_W'(trial - {1'b0, apply}) : trial[Q16_W-1:0];
      quo <= {quo[Q16_W-2:0], fits};
    end
    if (cmd.store) begin
      if (cmd.sel) clu_res <= quo;
      else thr_res <= quo;
    end
  end

  assign gear         = GEAR_W'(gear_res);
  assign clutch_out   = clu_res;
  assign throttle_out = thr_res;
  assign busy_res     = busy_q;

endmodule

`default_nettype wire

// File: rtl/timed_clutch_gear_shift_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Timed clutch gear-shift sequencer. Each request carries the throttle and
// clutch demands (q0.16), both shift buttons and a millisecond timestamp, and
// gives one result: gear, effective clutch and throttle, and a busy flag. A
// fresh button press starts a shift: throttle cut and clutch open up to the
// depress time (optional throttle blip on a downshift), then both demands
// ramp by elapsed/apply time, the gear steps once after the depress time and
// the demands pass through again after the apply time. One request is in
// flight at a time. A request that needs no ramp goes from the evaluate state
// straight to the output state; one in the ramp window also passes through a shared
// 16-bit restoring divider that runs one quotient bit a cycle, first for the
// throttle, then for the clutch. The next request is accepted the cycle after
// the result is taken. Configuration writes are taken at any time outside
// reset and must only be made while no request is in flight. No clearing pass
// after reset.

module timed_clutch_gear_shift_sequencer #(
  parameter int GEAR_SLOTS = tcgs_pkg::GEAR_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  tcgs_req_if.sink   req,
  tcgs_res_if.source res,
  tcgs_cfg_if.sink   cfg
);
  import tcgs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = !rst;

  tcgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcgs_dp #(
    .GEAR_SLOTS (GEAR_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .throttle_in    (req.throttle_in),
    .clutch_in      (req.clutch_in),
    .shift_up_btn   (req.shift_up_btn),
    .shift_down_btn (req.shift_down_btn),
    .now_ms         (req.now_ms),
    .cmd            (cmd),
    .sts            (sts),
    .gear           (res.gear),
    .clutch_out     (res.clutch_out),
    .throttle_out   (res.throttle_out),
    .busy_res       (res.busy_res)
  );

endmodule

`default_nettype wire

// File: rtl/tcgs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  gear,
  input logic [15:0] clutch_out,
  input logic [15:0] throttle_out,
  input logic        busy_res
);

  logic       pending;
  logic       have_last;
  logic [3:0] last_gear;
  logic [3:0] gear_diff;
  logic       req_acc;
  logic       res_acc;

  assign req_acc   = req_valid && req_ready;
  assign res_acc   = res_valid && res_ready;
  assign gear_diff = gear - last_gear;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      have_last <= 1'b0;
      last_gear <= '0;
    end else begin
      if (req_acc) pending <= 1'b1;
      else if (res_acc) pending <= 1'b0;
      if (res_acc) begin
        have_last <= 1'b1;
        last_gear <= gear;
      end
    end
  end

  // a result only follows an accepted request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending)
    else $error("result without request");

  // one request in flight: no accept while a result waits
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request accepted while result pending");

  // gear moves by at most one step between results
  a_gear_step: assert property (@(posedge clk) disable iff (rst)
    (res_acc && have_last) |-> (gear_diff == 4'h0 || gear_diff == 4'h1 || gear_diff == 4'hF))
    else $error("gear jumped");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable({gear, clutch_out, throttle_out, busy_res})))
    else $error("stalled result changed");

endmodule

bind timed_clutch_gear_shift_sequencer tcgs_checker u_tcgs_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .gear         (res.gear),
  .clutch_out   (res.clutch_out),
  .throttle_out (res.throttle_out),
  .busy_res     (res.busy_res)
);

`default_nettype wire

// File: tb/timed_clutch_gear_shift_sequencer_tb.sv
`timescale 1ns / 1ps

module timed_clutch_gear_shift_sequencer_tb;
  import tcgs_pkg::*;

  localparam int GEAR_MAX    = GEAR_SLOTS_DEF;
  localparam int ITEM_TARGET = 1750;
  localparam int PHASES      = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [15:0] throttle;
    logic [15:0] clutch;
    logic        up;
    logic        down;
    logic [31:0] stamp;
  } tick_t;

  typedef struct packed {
    logic signed [3:0] gear;
    logic [15:0]       clutch;
    logic [15:0]       throttle;
    logic              busy;
  } gearbox_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcgs_req_if req ();
  tcgs_res_if res ();
  tcgs_cfg_if cfg ();

  timed_clutch_gear_shift_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  always #1 clk = ~clk;

  tick_t        tick_q[$];
  gearbox_out_t gearbox_out_q[$];
  tick_t        tick_hold;
  int           errors = 0;
  int           watchdog = 0;
  int           queued = 0;
  int           launched = 0;
  int           results_seen = 0;
  bit           idling = 1'b1;
  int           req_gap = 0;
  int           res_stall = 0;
  logic [31:0]  stamp_gen = '0;
  bit           lean_up = 1'b1;

  cfg_reg_t     reg_order [5] = '{REG_DEPRESS, REG_APPLY, REG_TOP, REG_BLIP, REG_AUTO};
  logic [15:0]  reg_val [0:4];

  // register shadow
  logic [15:0]  depress_ms = DEPRESS_RST;
  logic [15:0]  apply_ms   = APPLY_RST;
  logic [2:0]   top_cfg    = TOP_RST;
  logic         blip_cfg   = BLIP_RST;
  logic         manual_cfg = AUTO_RST;

  // gearbox state
  int           gear_cur = 0;
  bit           up_run = 1'b0;
  bit           down_run = 1'b0;
  bit           stepped = 1'b0;
  logic [31:0]  start_ms = '0;
  bit           up_prev = 1'b0;
  bit           down_prev = 1'b0;

  function automatic logic [15:0] ramp_q16(logic [31:0] el, logic [15:0] demand);
    logic [63:0] prod;
    prod = 64'(el) * 64'(demand);
    return 16'(prod / 64'(apply_ms));
  endfunction

  function automatic gearbox_out_t gearbox_step(tick_t t);
    gearbox_out_t o;
    int           top;
    int           dir;
    int           g;
    logic [31:0]  el;
    bit           running;
    bit           active;
    o.clutch   = t.clutch;
    o.throttle = t.throttle;
    top = (int'(top_cfg) > GEAR_MAX) ? GEAR_MAX : int'(top_cfg);
    running = 1'b0;
    dir = 0;
    if ((t.up && gear_cur < top) || up_run) begin
      if (!up_prev && !up_run) begin
        start_ms = t.stamp;
        up_run = 1'b1;
        stepped = 1'b0;
      end else if (up_run) begin
        running = 1'b1;
        dir = 1;
      end
    end else if ((t.down && gear_cur >= 0) || down_run) begin
      if (!down_prev && !down_run) begin
        start_ms = t.stamp;
        down_run = 1'b1;
        stepped = 1'b0;
      end else if (down_run) begin
        running = 1'b1;
        dir = -1;
      end
    end
    if (running) begin
      el = t.stamp - start_ms;
      active = 1'b1;
      o.throttle = '0;
      if (el < depress_ms) begin
        o.clutch = '0;
        if (dir < 0 && blip_cfg && manual_cfg && gear_cur > 1) o.throttle = BLIP_Q16;
      end else if (el > depress_ms && el < apply_ms) begin
        o.throttle = ramp_q16(el, t.throttle);
        o.clutch   = ramp_q16(el, t.clutch);
      end
      if (el > apply_ms) begin
        o.throttle = t.throttle;
        o.clutch   = t.clutch;
        active = 1'b0;
      end
      if (!stepped && el > depress_ms) begin
        g = gear_cur + dir;
        if (g > GEAR_MAX) g = GEAR_MAX;
        if (g < -1) g = -1;
        gear_cur = g;
        stepped = 1'b1;
      end
      if (dir > 0) up_run = active;
      else down_run = active;
    end
    up_prev = t.up;
    down_prev = t.down;
    el = t.stamp - start_ms;
    // manual mode (auto off) forgets the buttons once past the depress window
    if (el > depress_ms && !manual_cfg) begin
      up_prev = 1'b0;
      down_prev = 1'b0;
    end
    o.gear = gear_cur[3:0];
    o.busy = up_run || down_run;
    return o;
  endfunction

  function automatic logic [15:0] any_demand();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_tick(input logic [15:0] thr, input logic [15:0] clu, input logic up,
                          input logic dn, input logic [31:0] stamp);
    tick_t t;
    t.throttle = thr;
    t.clutch   = clu;
    t.up       = up;
    t.down     = dn;
    t.stamp    = stamp;
    tick_q.push_back(t);
    queued++;
  endtask

  // release, fresh press, then ticks walking through both windows
  task automatic shift_sequence(input bit go_up);
    logic [31:0] mark;
    logic [31:0] offset;
    logic [31:0] span;
    logic [31:0] target;
    logic        up_lvl;
    logic        dn_lvl;
    bit          held;
    bit          both;
    int          n;
    if ($urandom_range(0, 9) == 0) stamp_gen = 32'hFFFF_FFFF - $urandom_range(0, 400);
    stamp_gen += $urandom_range(0, 3);
    add_tick(any_demand(), any_demand(), 1'b0, 1'b0, stamp_gen);
    stamp_gen += $urandom_range(0, 3);
    mark = stamp_gen;
    both = ($urandom_range(0, 5) == 0);
    add_tick(any_demand(), any_demand(), go_up | both, !go_up | both, mark);
    span = 32'((depress_ms > apply_ms) ? depress_ms : apply_ms) + 2;
    offset = '0;
    held = 1'($urandom_range(0, 1));
    n = 0;
    while (offset <= span && n < 14) begin
      case ($urandom_range(0, 11))
        0: target = 32'(depress_ms);
        1: target = 32'(depress_ms) + 1;
        2: target = 32'(apply_ms);
        3: target = 32'(apply_ms) + 1;
        4: target = (depress_ms == 0) ? 32'd0 : 32'(depress_ms) - 1;
        default: target = offset + $urandom_range(0, span / 5 + 1);
      endcase
      if (target > offset) offset = target;
      up_lvl = go_up ? held : 1'b0;
      dn_lvl = go_up ? 1'b0 : held;
      if ($urandom_range(0, 11) == 0) begin
        up_lvl = 1'($urandom_range(0, 1));
        dn_lvl = 1'($urandom_range(0, 1));
      end
      stamp_gen = mark + offset;
      add_tick(any_demand(), any_demand(), up_lvl, dn_lvl, stamp_gen);
      n++;
    end
    if (offset <= span) begin
      stamp_gen = mark + span + $urandom_range(0, 5);
      add_tick(any_demand(), any_demand(), 1'b0, 1'b0, stamp_gen);
    end
  endtask

  task automatic noise_tick();
    if ($urandom_range(0, 3) == 0) stamp_gen = $urandom;
    else stamp_gen += $urandom_range(0, 2 * apply_ms + 2);
    add_tick(any_demand(), any_demand(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             stamp_gen);
  endtask

  task automatic set_regs(input int dep, input int app, input int top, input int blip,
                          input int man);
    reg_val[REG_DEPRESS] = 16'(dep);
    reg_val[REG_APPLY]   = 16'(app);
    reg_val[REG_TOP]     = 16'(top);
    reg_val[REG_BLIP]    = 16'(blip);
    reg_val[REG_AUTO]    = 16'(man);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 5; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= reg_order[i];
      cfg.data  <= reg_val[reg_order[i]];
      do @(posedge clk); while (!cfg.ready);
      case (reg_order[i])
        REG_DEPRESS: depress_ms = reg_val[REG_DEPRESS];
        REG_APPLY:   apply_ms   = reg_val[REG_APPLY];
        REG_TOP:     top_cfg    = reg_val[REG_TOP][2:0];
        REG_BLIP:    blip_cfg   = reg_val[REG_BLIP][0];
        REG_AUTO:    manual_cfg = reg_val[REG_AUTO][0];
        default: ;
      endcase
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || launched != results_seen) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    gearbox_out_t want;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        want = gearbox_step(tick_hold);
        gearbox_out_q.push_back(want);
      end
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req.valid <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
          req_gap = $urandom_range(0, 13);
          req.valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          tick_hold = tick_q.pop_front();
          launched++;
          req.throttle_in    <= tick_hold.throttle;
          req.clutch_in      <= tick_hold.clutch;
          req.shift_up_btn   <= tick_hold.up;
          req.shift_down_btn <= tick_hold.down;
          req.now_ms         <= tick_hold.stamp;
          req.valid          <= 1'b1;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    gearbox_out_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        results_seen++;
        if (gearbox_out_q.size() == 0) begin
          errors++;
          $error("result with no request pending: gear %0d", res.gear);
        end else begin
          want = gearbox_out_q.pop_front();
          if (res.gear !== want.gear) begin
            errors++;
            $error("gear: expected %0d, got %0d", want.gear, res.gear);
          end
          if (res.clutch_out !== want.clutch) begin
            errors++;
            $error("clutch_out: expected %0d, got %0d", want.clutch, res.clutch_out);
          end
          if (res.throttle_out !== want.throttle) begin
            errors++;
            $error("throttle_out: expected %0d, got %0d", want.throttle, res.throttle_out);
          end
          if (res.busy_res !== want.busy) begin
            errors++;
            $error("busy_res: expected %0d, got %0d", want.busy, res.busy_res);
          end
        end
      end
      if (res_stall > 0) begin
        res_stall--;
        res.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        res_stall = $urandom_range(0, 13);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        watchdog = 0;
      else
        watchdog++;
      if (watchdog >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int quota;
    req.valid          = 1'b0;
    req.throttle_in    = '0;
    req.clutch_in      = '0;
    req.shift_up_btn   = 1'b0;
    req.shift_down_btn = 1'b0;
    req.now_ms         = '0;
    res.ready          = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = REG_DEPRESS;
    cfg.data           = '0;

    // reset settings: depress 100, apply 300, top 6
    add_tick(16'd0, 16'hFFFF, 1'b0, 1'b0, 32'd0);
    add_tick(16'hFFFF, 16'd0, 1'b0, 1'b0, 32'd5);
    add_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 32'd10);
    add_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 32'd60);
    add_tick(16'd40000, 16'd50000, 1'b0, 1'b0, 32'd110);
    add_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd111);
    add_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd309);
    add_tick(16'd1234, 16'd4321, 1'b0, 1'b0, 32'd310);
    add_tick(16'd1234, 16'd4321, 1'b0, 1'b0, 32'd311);
    // down from reverse is refused
    add_tick(16'd500, 16'd600, 1'b0, 1'b1, 32'd320);
    // up wins when both are pressed
    add_tick(16'd500, 16'd600, 1'b1, 1'b1, 32'd330);
    add_tick(16'd500, 16'd600, 1'b0, 1'b1, 32'd340);
    add_tick(16'd500, 16'd600, 1'b1, 1'b0, 32'd500);
    add_tick(16'd0, 16'd0, 1'b0, 1'b0, 32'd700);
    // timestamp wraps mid shift
    add_tick(16'd7, 16'd9, 1'b0, 1'b0, 32'hFFFF_FFE0);
    add_tick(16'd7, 16'd9, 1'b1, 1'b0, 32'hFFFF_FFF0);
    add_tick(16'hFFFF, 16'h8000, 1'b1, 1'b0, 32'h0000_0100);
    add_tick(16'hFFFF, 16'h8000, 1'b0, 1'b0, 32'h0000_0200);
    stamp_gen = 32'h0000_0300;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(0, 0, 7, 1, 1);
        1: set_regs(65535, 65535, 1, 0, 0);
        2: set_regs(65535, 0, 7, 1, 0);
        3: set_regs(0, 65535, 3, 1, 1);
        4: set_regs(10, 40, 7, 1, 1);
        5: set_regs(5, 20, 6, 0, 0);
        default: set_regs($urandom_range(0, 30), $urandom_range(0, 60), $urandom_range(1, 7),
                          $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      program_regs();
      idling = (p != PHASES - 1);
      quota = queued + ITEM_TARGET / PHASES;
      while (queued < quota) begin
        if ($urandom_range(0, 7) == 0) lean_up = !lean_up;
        if ($urandom_range(0, 6) == 0)
          noise_tick();
        else
          shift_sequence(lean_up ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && gearbox_out_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tcgs_pkg.sv
rtl/tcgs_ifs.sv
rtl/tcgs_ctrl.sv
rtl/tcgs_dp.sv
rtl/timed_clutch_gear_shift_sequencer.sv
rtl/tcgs_checker.sv
tb/timed_clutch_gear_shift_sequencer_tb.sv
